// ===== src/ppaa_pkg.sv =====
// Shared types, constants and the arctangent table for the aim angle block.
`timescale 1ns / 1ps

package ppaa_pkg;

  // Field widths fixed by the interface.
  localparam int COORD_W = 16;
  localparam int H_W     = 16;
  localparam int ANGLE_W = 16;

  // CORDIC datapath widths: coordinates enter shifted up by PRE_SHIFT bits,
  // the angle accumulator holds radians with 40 fraction bits.
  localparam int PRE_SHIFT = 20;
  localparam int X_W       = 40;
  localparam int Z_W       = 42;
  localparam int MAX_STEPS = 24;
  localparam int STEP_W    = $clog2(MAX_STEPS);

  // Radian to degree scaling: deg = mag * 225000 / 3927, then round to Q8.8.
  localparam int MAG_W       = Z_W - 1;
  localparam int MAG_LO_W    = 20;
  localparam int DEG_MUL_W   = 18;
  localparam int P_HI_W      = MAG_W - MAG_LO_W + DEG_MUL_W;
  localparam int P_LO_W      = MAG_LO_W + DEG_MUL_W;
  localparam int ACC_W       = P_HI_W + MAG_LO_W;
  localparam int ROUND_SHIFT = 32;
  localparam int B_W         = ACC_W - ROUND_SHIFT;
  localparam int RECIP_W     = 29;
  localparam int PROD_W      = B_W + RECIP_W;
  localparam int RECIP_SHIFT = 40;
  localparam int Q_W         = 15;
  localparam int DEG_DIV     = 3927;

  localparam logic [DEG_MUL_W-1:0] DEG_MUL   = 18'd225000;
  localparam logic [RECIP_W-1:0]   RECIP_DIV = 29'd279987682;
  localparam logic [ACC_W-1:0]     ROUND_ADD = ACC_W'(DEG_DIV) << (ROUND_SHIFT - 1);
  localparam logic [Q_W-1:0]       DEG90_Q8  = 15'd23040;

  localparam logic [H_W-1:0] HEIGHT_RESET = 16'd1000;

  // One arctangent channel of the CORDIC.
  typedef struct packed {
    logic signed [X_W-1:0] x;
    logic signed [X_W-1:0] y;
    logic signed [Z_W-1:0] z;
  } lane_t;

  // Word carried through the CORDIC stages: lane 0 is yaw, lane 1 is pitch.
  typedef struct packed {
    lane_t [1:0] lane;
    logic  [1:0] zero;
    logic  [1:0] neg;
    logic        h_zero;
    logic        last;
  } cordic_item_t;

  // atan(2^-i) in radians with 40 fraction bits, rounded to nearest.
  function automatic logic signed [Z_W-1:0] atan_q40(input logic [STEP_W-1:0] i);
    logic signed [Z_W-1:0] v;
    unique case (i)
      5'd0:    v = 42'sd863554413089;
      5'd1:    v = 42'sd509785937287;
      5'd2:    v = 42'sd269356888665;
      5'd3:    v = 42'sd136729762476;
      5'd4:    v = 42'sd68630207382;
      5'd5:    v = 42'sd34348560106;
      5'd6:    v = 42'sd17178471287;
      5'd7:    v = 42'sd8589759836;
      5'd8:    v = 42'sd4294945451;
      5'd9:    v = 42'sd2147480917;
      5'd10:   v = 42'sd1073741483;
      5'd11:   v = 42'sd536870869;
      5'd12:   v = 42'sd268435451;
      5'd13:   v = 42'sd134217727;
      5'd14:   v = 42'sd67108864;
      5'd15:   v = 42'sd33554432;
      5'd16:   v = 42'sd16777216;
      5'd17:   v = 42'sd8388608;
      5'd18:   v = 42'sd4194304;
      5'd19:   v = 42'sd2097152;
      5'd20:   v = 42'sd1048576;
      5'd21:   v = 42'sd524288;
      5'd22:   v = 42'sd262144;
      5'd23:   v = 42'sd131072;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/ppaa_ifs.sv =====
// Handshake channel interfaces for target points and aim angles.
`timescale 1ns / 1ps

interface ppaa_point_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] x_offset;
  logic signed [15:0] y_offset;
  logic               last_point;

  modport source (output valid, x_offset, y_offset, last_point, input ready);
  modport sink   (input valid, x_offset, y_offset, last_point, output ready);
endinterface

interface ppaa_aim_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] yaw_deg;
  logic signed [15:0] pitch_deg;
  logic               last_point_out;

  modport source (output valid, yaw_deg, pitch_deg, last_point_out, input ready);
  modport sink   (input valid, yaw_deg, pitch_deg, last_point_out, output ready);
endinterface

// ===== src/planar_point_to_aim_angles_core.sv =====
// Throughput: one point per cycle while no stalled result backs up the stages.
// Each CORDIC micro-rotation and each scaling step is a stage.
// A stalled result holds the output register and each full stage behind it; empty stages upstream keep taking points.
// Reset (rst, synchronous) empties the pipeline and sets plane_height to 1000.
// Top level: maps a point on a plane at a set height to yaw and pitch aim angles.
`timescale 1ns / 1ps

module planar_point_to_aim_angles_core
  import ppaa_pkg::*;
#(
  parameter int CORDIC_STEPS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_wr_en,
  input  logic [H_W-1:0] cfg_wr_data,
  ppaa_point_if.sink     point,
  ppaa_aim_if.source     aim
);

  logic [H_W-1:0] plane_height;
  cordic_item_t   entry;
  cordic_item_t   stage_item  [CORDIC_STEPS+1];
  logic           stage_valid [CORDIC_STEPS+1];
  logic           stage_ready [CORDIC_STEPS+1];

  // Height register; the user must write it only while the block is idle, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      plane_height <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      plane_height <= cfg_wr_data;
    end
  end

  // Build the first CORDIC word: x is the height, y the coordinate, both scaled up.
  always_comb begin
    entry.lane[0].x = X_W'({plane_height, PRE_SHIFT'(0)});
    entry.lane[1].x = X_W'({plane_height, PRE_SHIFT'(0)});
    entry.lane[0].y = X_W'($signed({point.x_offset, PRE_SHIFT'(0)}));
    entry.lane[1].y = X_W'($signed({point.y_offset, PRE_SHIFT'(0)}));
    entry.lane[0].z = '0;
    entry.lane[1].z = '0;
    entry.zero[0]   = (point.x_offset == '0);
    entry.zero[1]   = (point.y_offset == '0);
    entry.neg[0]    = point.x_offset[COORD_W-1];
    entry.neg[1]    = point.y_offset[COORD_W-1];
    entry.h_zero    = (plane_height == '0);
    entry.last      = point.last_point;
  end

  assign stage_valid[0] = point.valid;
  assign stage_item[0]  = entry;
  assign point.ready    = stage_ready[0];

  // One register stage per micro-rotation.
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    ppaa_cordic_stage #(
      .STEP(k)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (stage_valid[k]),
      .in_item  (stage_item[k]),
      .in_ready (stage_ready[k]),
      .out_valid(stage_valid[k+1]),
      .out_item (stage_item[k+1]),
      .out_ready(stage_ready[k+1])
    );
  end

  // Degree conversion and output register.
  ppaa_scale u_scale (
    .clk     (clk),
    .rst     (rst),
    .in_valid(stage_valid[CORDIC_STEPS]),
    .in_item (stage_item[CORDIC_STEPS]),
    .in_ready(stage_ready[CORDIC_STEPS]),
    .aim     (aim)
  );

  // Reset brings the height back to its default.
  assert property (@(posedge clk)
    rst |=> plane_height == HEIGHT_RESET)
    else $error("plane height not restored by reset");

  // Points are refused only when every stage is full and the result is stalled.
  assert property (@(posedge clk) disable iff (rst)
    !point.ready |-> aim.valid && !aim.ready)
    else $error("input stalled while the output is free");

endmodule

// ===== src/ppaa_cordic_stage.sv =====
// One registered CORDIC vectoring micro-rotation for both aim channels.
`timescale 1ns / 1ps

module ppaa_cordic_stage
  import ppaa_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  cordic_item_t in_item,
  output logic         in_ready,
  output logic         out_valid,
  output cordic_item_t out_item,
  input  logic         out_ready
);

  cordic_item_t item_next;

  // The stage takes a new word when it is empty or its word moves on.
  assign in_ready = !out_valid || out_ready;

  // Rotate toward the x axis: the sign of y picks the direction.
  always_comb begin
    logic signed [X_W-1:0] xv;
    logic signed [X_W-1:0] yv;
    logic signed [X_W-1:0] dx;
    logic signed [X_W-1:0] dy;
    logic signed [Z_W-1:0] angle;
    item_next = in_item;
    angle     = atan_q40(STEP_W'(STEP));
    for (int a = 0; a < 2; a++) begin
      xv = in_item.lane[a].x;
      yv = in_item.lane[a].y;
      dx = yv >>> STEP;
      dy = xv >>> STEP;
      if (!yv[X_W-1]) begin
        item_next.lane[a].x = xv + dx;
        item_next.lane[a].y = yv - dy;
        item_next.lane[a].z = in_item.lane[a].z + angle;
      end else begin
        item_next.lane[a].x = xv - dx;
        item_next.lane[a].y = yv + dy;
        item_next.lane[a].z = in_item.lane[a].z - angle;
      end
    end
  end

  // Valid bit with reset; the word itself needs none.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_item <= item_next;
    end
  end

  // x starts at the nonnegative height and only grows, so it never wraps.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !out_item.lane[0].x[X_W-1] && !out_item.lane[1].x[X_W-1])
    else $error("CORDIC x register overflowed");

endmodule

// ===== src/ppaa_scale.sv =====
// Pipeline that turns CORDIC radian angles into rounded, saturated Q8.8 degrees.
`timescale 1ns / 1ps

module ppaa_scale
  import ppaa_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  cordic_item_t in_item,
  output logic         in_ready,
  ppaa_aim_if.source   aim
);

  typedef struct packed {
    logic zero;
    logic cneg;
    logic zneg;
  } aflag_t;

  typedef struct packed {
    logic        h_zero;
    logic        last;
    aflag_t [1:0] f;
  } meta_t;

  logic v1, v2, v3, v4, v5, v6;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;
  meta_t m1, m2, m3, m4, m5;
  meta_t m1_next;

  logic [MAG_W-1:0]  mag1 [2];
  logic [P_HI_W-1:0] phi2 [2];
  logic [P_LO_W-1:0] plo2 [2];
  logic [B_W-1:0]    b3   [2];
  logic [B_W-1:0]    b4   [2];
  logic [Q_W-1:0]    qe4  [2];
  logic [Q_W-1:0]    q5   [2];

  logic [MAG_W-1:0]   mag_next   [2];
  logic [ACC_W-1:0]   acc        [2];
  logic [PROD_W-1:0]  prod       [2];
  logic [B_W-1:0]     rem        [2];
  logic [Q_W-1:0]     q_fix      [2];
  logic [Q_W-1:0]     q_sat      [2];
  logic [ANGLE_W-1:0] angle_next [2];

  logic [ANGLE_W-1:0] yaw;
  logic [ANGLE_W-1:0] pitch;
  logic               last;

  // Each stage loads when empty or when the stage after it moves.
  assign rdy6     = !v6 || aim.ready;
  assign rdy5     = !v5 || rdy6;
  assign rdy4     = !v4 || rdy5;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  // Stage 1 logic: magnitude and sign of the accumulated angle.
  always_comb begin
    m1_next.h_zero = in_item.h_zero;
    m1_next.last   = in_item.last;
    for (int a = 0; a < 2; a++) begin
      m1_next.f[a].zero = in_item.zero[a];
      m1_next.f[a].cneg = in_item.neg[a];
      m1_next.f[a].zneg = in_item.lane[a].z[Z_W-1];
      mag_next[a] = in_item.lane[a].z[Z_W-1] ? MAG_W'(-in_item.lane[a].z)
                                              : MAG_W'(in_item.lane[a].z);
    end
  end

  // Stage 3 logic: join the partial products, add the rounding half, drop 32 bits.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      acc[a] = {phi2[a], MAG_LO_W'(0)} + ACC_W'(plo2[a]) + ROUND_ADD;
    end
  end

  // Stage 4 logic: quotient estimate by reciprocal multiplication.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      prod[a] = PROD_W'(b3[a]) * PROD_W'(RECIP_DIV);
    end
  end

  // Stage 5 logic: the estimate is low by at most one, fix it and saturate.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      rem[a]   = b4[a] - B_W'(qe4[a]) * B_W'(DEG_DIV);
      q_fix[a] = (rem[a] >= B_W'(DEG_DIV)) ? qe4[a] + Q_W'(1) : qe4[a];
      q_sat[a] = (q_fix[a] > DEG90_Q8) ? DEG90_Q8 : q_fix[a];
    end
  end

  // Stage 6 logic: apply the sign, or the zero coordinate and zero height cases.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      if (m5.f[a].zero) begin
        angle_next[a] = '0;
      end else if (m5.h_zero) begin
        angle_next[a] = m5.f[a].cneg ? '0 - ANGLE_W'(DEG90_Q8) : ANGLE_W'(DEG90_Q8);
      end else begin
        angle_next[a] = m5.f[a].zneg ? '0 - ANGLE_W'(q5[a]) : ANGLE_W'(q5[a]);
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
      if (rdy6) v6 <= v5;
    end
  end

  // Data registers of all stages; stage 2 holds the two partial products.
  always_ff @(posedge clk) begin
    if (rdy1) begin
      m1 <= m1_next;
      for (int a = 0; a < 2; a++) mag1[a] <= mag_next[a];
    end
    if (rdy2) begin
      m2 <= m1;
      for (int a = 0; a < 2; a++) begin
        phi2[a] <= P_HI_W'(mag1[a][MAG_W-1:MAG_LO_W]) * P_HI_W'(DEG_MUL);
        plo2[a] <= P_LO_W'(mag1[a][MAG_LO_W-1:0]) * P_LO_W'(DEG_MUL);
      end
    end
    if (rdy3) begin
      m3 <= m2;
      for (int a = 0; a < 2; a++) b3[a] <= acc[a][ACC_W-1:ROUND_SHIFT];
    end
    if (rdy4) begin
      m4 <= m3;
      for (int a = 0; a < 2; a++) begin
        b4[a]  <= b3[a];
        qe4[a] <= prod[a][RECIP_SHIFT+Q_W-1:RECIP_SHIFT];
      end
    end
    if (rdy5) begin
      m5 <= m4;
      for (int a = 0; a < 2; a++) q5[a] <= q_sat[a];
    end
    if (rdy6) begin
      yaw   <= angle_next[0];
      pitch <= angle_next[1];
      last  <= m5.last;
    end
  end

  // Output register drives the result channel.
  assign aim.valid          = v6;
  assign aim.yaw_deg        = yaw;
  assign aim.pitch_deg      = pitch;
  assign aim.last_point_out = last;

  // The reciprocal estimate must never be off by more than one.
  assert property (@(posedge clk) disable iff (rst)
    v4 |-> (rem[0] < B_W'(2 * DEG_DIV)) && (rem[1] < B_W'(2 * DEG_DIV)))
    else $error("reciprocal quotient estimate out of range");

  // Every result stays within plus and minus 90 degrees.
  assert property (@(posedge clk) disable iff (rst)
    aim.valid |-> ($signed(aim.yaw_deg) <= 16'sd23040) && ($signed(aim.yaw_deg) >= -16'sd23040)
               && ($signed(aim.pitch_deg) <= 16'sd23040)
               && ($signed(aim.pitch_deg) >= -16'sd23040))
    else $error("aim angle outside +-90 degrees");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the aim angle core: directed table, then random points.
`timescale 1ns / 1ps

module tb
  import ppaa_pkg::*;
();

  localparam int STEPS          = 16;
  localparam int COORD_SHIFT    = 20;
  localparam int TAB_LEN        = 24;
  localparam int RESULT_LATENCY = STEPS + 6;
  localparam int IDLE_LIMIT     = 2000;
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 115;
  localparam logic [H_W-1:0]    HEIGHT_AFTER_RESET = 16'd1000;
  localparam logic signed [15:0] RIGHT_ANGLE       = 16'sd23040;

  // One row of the directed table: an optional height write, then one point.
  typedef struct {
    bit                 set_h;
    logic [H_W-1:0]     h;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               lst;
    bit                 fix_y;
    logic signed [15:0] ey;
    bit                 fix_p;
    logic signed [15:0] ep;
  } point_row_t;

  // Angles expected for one accepted point, with the allowed error per angle.
  typedef struct {
    logic signed [15:0] yaw;
    logic signed [15:0] pitch;
    logic               last;
    int                 yaw_tol;
    int                 pitch_tol;
  } aim_expect_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [H_W-1:0] cfg_wr_data;

  // Typed expectations travel beside the point word they belong to.
  logic               fix_yaw_en;
  logic signed [15:0] fix_yaw;
  logic               fix_pitch_en;
  logic signed [15:0] fix_pitch;

  logic [H_W-1:0] plane_h;
  longint signed  atan_tab [TAB_LEN];
  aim_expect_t    aim_expect_q [$];
  point_row_t     rows [$];
  bit             calm;
  int             err_cnt;
  int             points_in;
  int             words_checked;
  int             heights_used;
  int             idle_cycles;

  ppaa_point_if point_ch ();
  ppaa_aim_if   aim_ch ();

  planar_point_to_aim_angles_core #(
    .CORDIC_STEPS(STEPS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .point      (point_ch),
    .aim        (aim_ch)
  );

  always #2 clk = ~clk;

  // atan(1/n) in unsigned Q62 radians from the alternating power series.
  function automatic longint unsigned atan_inv_series(input longint unsigned n);
    longint unsigned p;
    longint unsigned sum;
    longint unsigned term;
    longint unsigned k;
    p   = (64'd1 << 62) / n;
    sum = 0;
    k   = 0;
    while (p != 0) begin
      term = p / (2 * k + 1);
      if (k[0] == 1'b0) sum += term;
      else sum -= term;
      p = p / (n * n);
      k++;
    end
    return sum;
  endfunction

  // Micro-rotation angles in Q40 radians; the first one is pi/4 built from two terms.
  initial begin
    longint unsigned q62;
    for (int i = 0; i < TAB_LEN; i++) begin
      if (i == 0) q62 = atan_inv_series(2) + atan_inv_series(3);
      else q62 = atan_inv_series(64'd1 << i);
      atan_tab[i] = longint'((q62 + (64'd1 << 21)) >> 22);
    end
  end

  // Vectoring CORDIC for atan2(c, h), scaled to Q8.8 degrees and rounded.
  function automatic logic signed [15:0] aim_angle_q8(input logic signed [15:0] c,
                                                      input logic [H_W-1:0] h);
    longint signed   xr;
    longint signed   yr;
    longint signed   z;
    longint signed   dx;
    longint signed   dy;
    longint unsigned mag;
    longint unsigned deg;
    longint unsigned q8;
    logic signed [15:0] r;
    if (c == 0) return 16'sd0;
    if (h == 0) return (c > 0) ? RIGHT_ANGLE : -RIGHT_ANGLE;
    xr = longint'(h) <<< COORD_SHIFT;
    yr = longint'(c) <<< COORD_SHIFT;
    z  = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = yr >>> i;
      dy = xr >>> i;
      if (yr >= 0) begin
        xr += dx;
        yr -= dy;
        z  += atan_tab[i];
      end else begin
        xr -= dx;
        yr += dy;
        z  -= atan_tab[i];
      end
    end
    mag = (z < 0) ? -z : z;
    deg = mag * 225000 / 3927;
    q8  = (deg + (64'd1 << 31)) >> 32;
    if (q8 > 23040) q8 = 23040;
    r = q8[15:0];
    return (z < 0) ? -r : r;
  endfunction

  // Every mismatch prints one line and is counted.
  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    $display("[%0t] mismatch: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_angle(input string what, input logic signed [15:0] got,
                             input logic signed [15:0] want, input int tol);
    int d;
    d = int'(got) - int'(want);
    if (d > tol || d < -tol) report_mismatch(what, got, want);
  endtask

  // Compare each result word with the oldest expectation, then predict new points.
  always @(posedge clk) begin
    aim_expect_t want;
    aim_expect_t pred;
    if (rst) begin
      plane_h <= HEIGHT_AFTER_RESET;
    end else begin
      if (aim_ch.valid && aim_ch.ready) begin
        if (aim_expect_q.size() == 0) begin
          report_mismatch("result word with nothing expected, yaw", aim_ch.yaw_deg, 0);
        end else begin
          want = aim_expect_q.pop_front();
          check_angle("yaw_deg", aim_ch.yaw_deg, want.yaw, want.yaw_tol);
          check_angle("pitch_deg", aim_ch.pitch_deg, want.pitch, want.pitch_tol);
          if (aim_ch.last_point_out !== want.last) begin
            report_mismatch("last_point_out", aim_ch.last_point_out, want.last);
          end
          words_checked++;
        end
      end
      if (point_ch.valid && point_ch.ready) begin
        pred.yaw       = aim_angle_q8(point_ch.x_offset, plane_h);
        pred.pitch     = aim_angle_q8(point_ch.y_offset, plane_h);
        pred.last      = point_ch.last_point;
        // Zero coordinates and zero height give exact answers.
        pred.yaw_tol   = (point_ch.x_offset == 0 || plane_h == 0) ? 0 : 1;
        pred.pitch_tol = (point_ch.y_offset == 0 || plane_h == 0) ? 0 : 1;
        if (fix_yaw_en) begin
          pred.yaw     = fix_yaw;
          pred.yaw_tol = 0;
        end
        if (fix_pitch_en) begin
          pred.pitch     = fix_pitch;
          pred.pitch_tol = 0;
        end
        aim_expect_q.push_back(pred);
        points_in++;
      end
      if (cfg_wr_en) plane_h <= cfg_wr_data;
    end
  end

  // Watchdog: ends the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (point_ch.valid && point_ch.ready) || (aim_ch.valid && aim_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[%0t] watchdog expired with %0d words outstanding", $time,
               aim_expect_q.size());
      $display("planar_point_to_aim_angles_core regression: fail");
      $finish;
    end
  end

  // Result side: random back-pressure before each word, none while calm.
  initial begin
    int gap;
    aim_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        aim_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      aim_ch.ready <= 1'b1;
      do @(posedge clk); while (!aim_ch.valid);
    end
  end

  task automatic add_row(input bit set_h, input logic [H_W-1:0] h,
                         input logic signed [15:0] x, input logic signed [15:0] y,
                         input logic lst, input bit fix_y, input logic signed [15:0] ey,
                         input bit fix_p, input logic signed [15:0] ep);
    point_row_t r;
    r.set_h = set_h;
    r.h     = h;
    r.x     = x;
    r.y     = y;
    r.lst   = lst;
    r.fix_y = fix_y;
    r.ey    = ey;
    r.fix_p = fix_p;
    r.ep    = ep;
    rows.push_back(r);
  endtask

  // Offer one point word after a random gap and hold it until it is taken.
  task automatic send_point(input logic signed [15:0] x, input logic signed [15:0] y,
                            input logic lst, input bit fy_en, input logic signed [15:0] fy,
                            input bit fp_en, input logic signed [15:0] fp);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      point_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    point_ch.valid      <= 1'b1;
    point_ch.x_offset   <= x;
    point_ch.y_offset   <= y;
    point_ch.last_point <= lst;
    fix_yaw_en          <= fy_en;
    fix_yaw             <= fy;
    fix_pitch_en        <= fp_en;
    fix_pitch           <= fp;
    do @(posedge clk); while (!point_ch.ready);
  endtask

  // Stop offering points and wait until every expected word has come back.
  task automatic drain_results();
    point_ch.valid <= 1'b0;
    @(posedge clk);
    while (aim_expect_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_height(input logic [H_W-1:0] h);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= h;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    heights_used++;
  endtask

  // Random coordinate: full range, small, near the height, extremes or scaled by height.
  function automatic logic signed [15:0] rand_coord(input logic [H_W-1:0] h);
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 65535)) - 32768;
      4, 5:       v = int'($urandom_range(0, 128)) - 64;
      6: begin
        v = int'(h) + int'($urandom_range(0, 16)) - 8;
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      7: begin
        case ($urandom_range(0, 4))
          0:       v = 32767;
          1:       v = -32768;
          2:       v = 0;
          3:       v = 1;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(0, 8 * int'(h))) - 4 * int'(h);
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Main sequence: reset, directed table, random phases over several heights.
  initial begin
    logic [H_W-1:0] h;
    point_ch.valid      <= 1'b0;
    point_ch.x_offset   <= '0;
    point_ch.y_offset   <= '0;
    point_ch.last_point <= 1'b0;
    fix_yaw_en          <= 1'b0;
    fix_yaw             <= '0;
    fix_pitch_en        <= 1'b0;
    fix_pitch           <= '0;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    rst                 <= 1'b1;
    calm                = 1'b0;

    // Height after reset, then extremes of coordinates and of the height.
    add_row(0, 0, 0, 0, 0, 1, 0, 1, 0);
    add_row(0, 0, 32767, -32768, 1, 0, 0, 0, 0);
    add_row(0, 0, -32768, 32767, 0, 0, 0, 0, 0);
    add_row(0, 0, 1, -1, 1, 0, 0, 0, 0);
    add_row(0, 0, 1000, -1000, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 32767, 1, 1, 0, 0, 0);
    add_row(0, 0, -1, 0, 0, 0, 0, 1, 0);
    add_row(0, 0, 16'sh5555, 16'shAAAA, 1, 0, 0, 0, 0);
    add_row(1, 1, 32767, -32768, 0, 0, 0, 0, 0);
    add_row(0, 0, 1, 1, 1, 0, 0, 0, 0);
    add_row(0, 0, 0, -1, 0, 1, 0, 0, 0);
    add_row(1, 65535, 1, -1, 0, 0, 0, 0, 0);
    add_row(0, 0, 32767, -32768, 1, 0, 0, 0, 0);
    add_row(0, 0, -32768, 0, 0, 0, 0, 1, 0);
    // Zero height pins every nonzero coordinate to a right angle.
    add_row(1, 0, 5, -5, 0, 1, RIGHT_ANGLE, 1, -RIGHT_ANGLE);
    add_row(0, 0, 0, -32768, 1, 1, 0, 1, -RIGHT_ANGLE);
    add_row(0, 0, 32767, 0, 0, 1, RIGHT_ANGLE, 1, 0);
    add_row(0, 0, -1, 1, 1, 1, -RIGHT_ANGLE, 1, RIGHT_ANGLE);
    add_row(1, 1000, 0, 0, 0, 1, 0, 1, 0);
    add_row(0, 0, 12345, -12345, 1, 0, 0, 0, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (rows[i]) begin
      if (rows[i].set_h) set_height(rows[i].h);
      send_point(rows[i].x, rows[i].y, rows[i].lst, rows[i].fix_y, rows[i].ey,
                 rows[i].fix_p, rows[i].ep);
    end

    // Random phases, one height each, with calm stretches drawn every few dozen points.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       h = HEIGHT_AFTER_RESET;
        1:       h = 16'd1;
        2:       h = 16'd65535;
        3:       h = H_W'($urandom_range(1, 16));
        4:       h = H_W'($urandom_range(1, 65535));
        5:       h = H_W'($urandom_range(100, 5000));
        6:       h = H_W'($urandom_range(1, 255));
        7:       h = 16'd32768;
        8:       h = 16'd0;
        default: h = H_W'($urandom_range(1, 65535));
      endcase
      set_height(h);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) calm = ($urandom_range(0, 3) == 0);
        // Sender holds off once until the pipeline has fully emptied.
        if (p == 5 && n == PHASE_ITEMS / 2) drain_results();
        send_point(rand_coord(h), rand_coord(h), 1'($urandom_range(0, 1)), 0, 0, 0, 0);
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (RESULT_LATENCY + 8) @(posedge clk);
    if (aim_expect_q.size() != 0) begin
      report_mismatch("expected words never delivered", aim_expect_q.size(), 0);
    end

    $display("Covered %0d points and %0d result words over %0d plane height settings,",
             points_in, words_checked, heights_used);
    $display("including height 1, 65535, zero height, zero and extreme coordinates.");
    if (err_cnt == 0) begin
      $display("planar_point_to_aim_angles_core regression: pass");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("planar_point_to_aim_angles_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ppaa_pkg.sv
src/ppaa_ifs.sv
src/ppaa_cordic_stage.sv
src/ppaa_scale.sv
src/planar_point_to_aim_angles_core.sv
dv/tb.sv
